// ===== src/tbrh_pkg.sv =====
// Package for the time-bucketed heart-rate histogram.
// Holds sizes, command and status codes, item types and the sequencer states.
// Depends on nothing.
`default_nettype none

package tbrh_pkg;

	// Store geometry.
	localparam int TIME_SLOTS = 96;
	localparam int RATE_BINS  = 256;
	localparam int COUNT_BITS = 16;

	localparam int DEPTH  = TIME_SLOTS * RATE_BINS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int BIN_W  = (RATE_BINS > 1) ? $clog2(RATE_BINS) : 1;
	localparam int SLOT_W = (TIME_SLOTS > 1) ? $clog2(TIME_SLOTS) : 1;

	// Datapath widths: bin rate value, total count, Q8 mean and the dividends.
	localparam int VAL_W  = $clog2(255 + RATE_BINS);
	localparam int N_W    = COUNT_BITS + BIN_W;
	localparam int M_W    = VAL_W + 8;
	localparam int D_W    = N_W + M_W;
	localparam int PROD_W = M_W + COUNT_BITS;

	// Time of day to slot: multiply by a rounded-up reciprocal of the slot length.
	localparam int MINUTES_PER_HOUR = 60;
	localparam int MINUTES_PER_SLOT = 15;
	localparam int RECIP_SHIFT      = 16;
	localparam int SLOT_RECIP       = (1 << RECIP_SHIFT) / MINUTES_PER_SLOT + 1;

	localparam int Q8_LIMIT        = 131071;
	localparam int COUNT_OUT_LIMIT = 16777215;
	localparam logic [7:0] LOWEST_RATE_RESET = 8'd30;

	// Register index of lowest_rate (bit 2 of the byte address).
	localparam logic REG_LOWEST_RATE = 1'b0;

	// Command codes.
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_QUERY  = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	// Status codes.
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_DROPPED = 2'd1;
	localparam logic [1:0] STATUS_EMPTY   = 2'd2;

	typedef struct packed {
		logic [1:0] cmd;
		logic [4:0] hour_of_day;
		logic [5:0] minute_of_hour;
		logic [8:0] beats_per_minute;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [23:0] sample_count;
		logic [16:0] mean_q8;
		logic [16:0] deviation_q8;
	} rsp_t;

	// Control from the sequencer to the multiply-accumulate pipeline.
	typedef struct packed {
		logic             clear;
		logic             pass_dev;
		logic             issue;
		logic [BIN_W-1:0] bin;
	} mac_ctrl_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_INS_RD,
		ST_INS_WR,
		ST_SUM,
		ST_DIV_MEAN,
		ST_DEV,
		ST_DIV_DEV,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== src/tbrh_store.sv =====
// Counter store: one write port and one read port with registered read data.
// Depends on tbrh_pkg.
`default_nettype none

module tbrh_store (
	input  wire logic                           clk,
	input  wire logic                           wr_en,
	input  wire logic [tbrh_pkg::ADDR_W-1:0]    wr_addr,
	input  wire logic [tbrh_pkg::COUNT_BITS-1:0] wr_data,
	input  wire logic                           rd_en,
	input  wire logic [tbrh_pkg::ADDR_W-1:0]    rd_addr,
	output logic      [tbrh_pkg::COUNT_BITS-1:0] rd_data
);

	logic [tbrh_pkg::COUNT_BITS-1:0] mem_q [tbrh_pkg::DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== src/tbrh_mac.sv =====
// Shared multiply-accumulate pipeline that walks one slot's counters.
// The first pass sums counts and rate times count, the second sums count times
// the distance from the mean. Depends on tbrh_pkg.
`default_nettype none

module tbrh_mac (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire tbrh_pkg::mac_ctrl_t             ctrl,
	input  wire logic [7:0]                      lowest,
	input  wire logic [tbrh_pkg::M_W-1:0]        mean,
	input  wire logic [tbrh_pkg::COUNT_BITS-1:0] rd_data,
	output logic                                 busy,
	output logic      [tbrh_pkg::N_W-1:0]        count_sum,
	output logic      [tbrh_pkg::D_W-1:0]        acc
);

	logic                              v_s1, v_s2, v_s3;
	logic [tbrh_pkg::BIN_W-1:0]        bin_s1;
	logic [tbrh_pkg::M_W-1:0]          op_s2;
	logic [tbrh_pkg::COUNT_BITS-1:0]   cnt_s2, cnt_s3;
	logic [tbrh_pkg::PROD_W-1:0]       prod_s3;
	logic [tbrh_pkg::VAL_W-1:0]        val;
	logic [tbrh_pkg::M_W-1:0]          val_q8;
	logic [tbrh_pkg::M_W-1:0]          mean_gap;

	// Rate of the bin whose counter just arrived, and its distance from the mean.
	always_comb begin
		val      = tbrh_pkg::VAL_W'(lowest) + tbrh_pkg::VAL_W'(bin_s1);
		val_q8   = {val, 8'b0};
		mean_gap = (val_q8 >= mean) ? (val_q8 - mean) : (mean - val_q8);
	end

	// Valid bits of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= ctrl.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Operand select, then multiply.
	always_ff @(posedge clk) begin
		bin_s1  <= ctrl.bin;
		cnt_s2  <= rd_data;
		op_s2   <= ctrl.pass_dev ? mean_gap : tbrh_pkg::M_W'(val);
		cnt_s3  <= cnt_s2;
		prod_s3 <= tbrh_pkg::PROD_W'(op_s2) * tbrh_pkg::PROD_W'(cnt_s2);
	end

	// Accumulators; the count total is only gathered on the first pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc       <= '0;
			count_sum <= '0;
		end else if (ctrl.clear) begin
			acc       <= '0;
			count_sum <= '0;
		end else if (v_s3) begin
			acc <= acc + tbrh_pkg::D_W'(prod_s3);
			if (!ctrl.pass_dev) begin
				count_sum <= count_sum + tbrh_pkg::N_W'(cnt_s3);
			end
		end
	end

	assign busy = v_s1 | v_s2 | v_s3;

endmodule

`default_nettype wire

// ===== src/tbrh_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by mean and deviation.
// Depends on tbrh_pkg.
`default_nettype none

module tbrh_div (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [tbrh_pkg::D_W-1:0] dividend,
	input  wire logic [tbrh_pkg::N_W-1:0] divisor,
	output logic                          busy,
	output logic      [tbrh_pkg::D_W-1:0] quotient
);

	localparam int CNT_W = $clog2(tbrh_pkg::D_W + 1);

	logic [CNT_W-1:0]           cnt_q;
	logic [tbrh_pkg::N_W-1:0]   rem_q;
	logic [tbrh_pkg::N_W-1:0]   div_q;
	logic [tbrh_pkg::N_W:0]     trial;
	logic                       fits;

	// One step: bring down the next dividend bit and try the subtract.
	always_comb begin
		trial = {rem_q, quotient[tbrh_pkg::D_W-1]};
		fits  = trial >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(tbrh_pkg::D_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// The quotient shifts in where the dividend shifts out.
	always_ff @(posedge clk) begin
		if (start) begin
			quotient <= dividend;
			rem_q    <= '0;
			div_q    <= divisor;
		end else if (cnt_q != '0) begin
			quotient <= {quotient[tbrh_pkg::D_W-2:0], fits};
			rem_q    <= fits ? tbrh_pkg::N_W'(trial - {1'b0, div_q})
			                 : trial[tbrh_pkg::N_W-1:0];
		end
	end

	assign busy = cnt_q != '0;

endmodule

`default_nettype wire

// ===== src/time_bucketed_rate_histogram.sv =====
// Time-bucketed heart-rate histogram: sequencer, register port and result stage.
// A stored insert reads and writes back one counter; a query of a filled slot walks the
// slot's counters twice through the single counter read port and uses the bit-serial divider
// after each walk; a clear sweeps the whole store. Dropped inserts and unused codes go straight to a result.
// One item is in work at a time. After reset the store is swept to zero, all DEPTH
// (24576) counters, with req_stall high; the lowest rate resets to 30.
`default_nettype none

module time_bucketed_rate_histogram (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_stall,
	input  wire tbrh_pkg::req_t  req,
	output logic                 rsp_valid,
	input  wire logic            rsp_stall,
	output tbrh_pkg::rsp_t       rsp,
	input  wire logic            psel,
	input  wire logic            penable,
	input  wire logic            pwrite,
	input  wire logic [2:0]      paddr,
	input  wire logic [31:0]     pwdata,
	output logic      [31:0]     prdata,
	output logic                 pready
);

	tbrh_pkg::state_t   state_q, state_d;
	tbrh_pkg::req_t     req_q;
	tbrh_pkg::rsp_t     res_q;
	tbrh_pkg::mac_ctrl_t mac_ctrl;

	logic                              init_q;
	logic [7:0]                        lowest_q;
	logic [tbrh_pkg::ADDR_W-1:0]       addr_q;
	logic [tbrh_pkg::BIN_W:0]          bin_q;
	logic [tbrh_pkg::M_W-1:0]          mean_q;
	logic [tbrh_pkg::N_W-1:0]          n_q;

	logic [10:0]                       minutes;
	logic [23:0]                       slot_prod;
	logic [7:0]                        slot_raw;
	logic                              slot_ok;
	logic [tbrh_pkg::SLOT_W-1:0]       slot_idx;
	logic [8:0]                        rate_off;
	logic                              rate_ok;
	logic [tbrh_pkg::ADDR_W-1:0]       row_base;
	logic [tbrh_pkg::ADDR_W-1:0]       ins_addr;
	logic                              walk_done;

	logic                              rd_en, wr_en;
	logic [tbrh_pkg::ADDR_W-1:0]       rd_addr, wr_addr;
	logic [tbrh_pkg::COUNT_BITS-1:0]   wr_data, rd_data;
	logic                              mac_busy;
	logic [tbrh_pkg::N_W-1:0]          count_sum;
	logic [tbrh_pkg::D_W-1:0]          acc;
	logic                              div_start, div_busy;
	logic [tbrh_pkg::D_W-1:0]          div_dividend, quotient;
	logic [tbrh_pkg::N_W-1:0]          div_divisor;

	logic [tbrh_pkg::D_W-1:0]          mean_ext, n_ext;
	logic                              req_take, rsp_load;

	// Configuration register port.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == tbrh_pkg::REG_LOWEST_RATE) ? {24'b0, lowest_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lowest_q <= tbrh_pkg::LOWEST_RATE_RESET;
		end else if (psel && penable && pwrite && pready &&
		             paddr[2] == tbrh_pkg::REG_LOWEST_RATE) begin
			lowest_q <= pwdata[7:0];
		end
	end

	// Slot and bin of the held item.
	always_comb begin
		minutes   = 11'(req_q.minute_of_hour) +
		            11'(req_q.hour_of_day) * 11'(tbrh_pkg::MINUTES_PER_HOUR);
		slot_prod = 24'(minutes) * 24'(tbrh_pkg::SLOT_RECIP);
		slot_raw  = slot_prod[tbrh_pkg::RECIP_SHIFT +: 8];
		slot_ok   = {1'b0, slot_raw} < 9'(tbrh_pkg::TIME_SLOTS);
		slot_idx  = slot_raw[tbrh_pkg::SLOT_W-1:0];
		rate_off  = req_q.beats_per_minute - 9'(lowest_q);
		rate_ok   = (req_q.beats_per_minute >= 9'(lowest_q)) &&
		            (11'(rate_off) < 11'(tbrh_pkg::RATE_BINS));
		row_base  = tbrh_pkg::ADDR_W'(slot_idx) * tbrh_pkg::ADDR_W'(tbrh_pkg::RATE_BINS);
		ins_addr  = row_base + tbrh_pkg::ADDR_W'(rate_off);
		walk_done = bin_q == (tbrh_pkg::BIN_W + 1)'(tbrh_pkg::RATE_BINS);
		mean_ext  = tbrh_pkg::D_W'(mean_q);
		n_ext     = tbrh_pkg::D_W'(n_q);
	end

	assign req_take = req_valid && !req_stall;
	assign rsp_load = (state_q == tbrh_pkg::ST_DONE) && (!rsp_valid || !rsp_stall);

	// Sequencer: next state and strobes to the store, pipeline and divider.
	always_comb begin
		state_d           = state_q;
		req_stall         = 1'b1;
		rd_en             = 1'b0;
		rd_addr           = row_base + tbrh_pkg::ADDR_W'(bin_q[tbrh_pkg::BIN_W-1:0]);
		wr_en             = 1'b0;
		wr_addr           = addr_q;
		wr_data           = '0;
		mac_ctrl.clear    = 1'b0;
		mac_ctrl.pass_dev = 1'b0;
		mac_ctrl.issue    = 1'b0;
		mac_ctrl.bin      = bin_q[tbrh_pkg::BIN_W-1:0];
		div_start         = 1'b0;
		div_dividend      = {acc[tbrh_pkg::D_W-9:0], 8'b0};
		div_divisor       = count_sum;
		unique case (state_q)
			tbrh_pkg::ST_CLEAR: begin
				wr_en = 1'b1;
				if (addr_q == tbrh_pkg::ADDR_W'(tbrh_pkg::DEPTH - 1)) begin
					state_d = init_q ? tbrh_pkg::ST_IDLE : tbrh_pkg::ST_DONE;
				end
			end
			tbrh_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_d = tbrh_pkg::ST_DECODE;
				end
			end
			tbrh_pkg::ST_DECODE: begin
				mac_ctrl.clear = 1'b1;
				case (req_q.cmd)
					tbrh_pkg::CMD_INSERT:
						state_d = (slot_ok && rate_ok) ? tbrh_pkg::ST_INS_RD : tbrh_pkg::ST_DONE;
					tbrh_pkg::CMD_QUERY:
						state_d = slot_ok ? tbrh_pkg::ST_SUM : tbrh_pkg::ST_DONE;
					tbrh_pkg::CMD_CLEAR:
						state_d = tbrh_pkg::ST_CLEAR;
					default:
						state_d = tbrh_pkg::ST_DONE;
				endcase
			end
			tbrh_pkg::ST_INS_RD: begin
				rd_en   = 1'b1;
				rd_addr = ins_addr;
				state_d = tbrh_pkg::ST_INS_WR;
			end
			tbrh_pkg::ST_INS_WR: begin
				wr_en   = 1'b1;
				wr_addr = ins_addr;
				wr_data = (&rd_data) ? rd_data : rd_data + 1'b1;
				state_d = tbrh_pkg::ST_DONE;
			end
			tbrh_pkg::ST_SUM: begin
				rd_en          = !walk_done;
				mac_ctrl.issue = !walk_done;
				if (walk_done && !mac_busy) begin
					if (count_sum == '0) begin
						state_d = tbrh_pkg::ST_DONE;
					end else begin
						div_start = 1'b1;
						state_d   = tbrh_pkg::ST_DIV_MEAN;
					end
				end
			end
			tbrh_pkg::ST_DIV_MEAN: begin
				if (!div_busy) begin
					mac_ctrl.clear = 1'b1;
					state_d        = tbrh_pkg::ST_DEV;
				end
			end
			tbrh_pkg::ST_DEV: begin
				mac_ctrl.pass_dev = 1'b1;
				rd_en             = !walk_done;
				mac_ctrl.issue    = !walk_done;
				div_dividend      = acc;
				div_divisor       = n_q;
				if (walk_done && !mac_busy) begin
					div_start = 1'b1;
					state_d   = tbrh_pkg::ST_DIV_DEV;
				end
			end
			tbrh_pkg::ST_DIV_DEV: begin
				mac_ctrl.pass_dev = 1'b1;
				if (!div_busy) begin
					state_d = tbrh_pkg::ST_DONE;
				end
			end
			tbrh_pkg::ST_DONE: begin
				if (rsp_load) begin
					state_d = tbrh_pkg::ST_IDLE;
				end
			end
			default: state_d = tbrh_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tbrh_pkg::ST_CLEAR;
			init_q  <= 1'b1;
			addr_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == tbrh_pkg::ST_CLEAR) begin
				if (state_d != tbrh_pkg::ST_CLEAR) begin
					init_q <= 1'b0;
					addr_q <= '0;
				end else begin
					addr_q <= addr_q + 1'b1;
				end
			end
		end
	end

	// Held item, walk counter and result fields.
	always_ff @(posedge clk) begin
		if (req_take) begin
			req_q <= req;
		end
		case (state_q)
			tbrh_pkg::ST_DECODE: begin
				bin_q              <= '0;
				res_q.sample_count <= '0;
				res_q.mean_q8      <= '0;
				res_q.deviation_q8 <= '0;
				case (req_q.cmd)
					tbrh_pkg::CMD_INSERT:
						res_q.status <= (slot_ok && rate_ok) ? tbrh_pkg::STATUS_OK
						                                     : tbrh_pkg::STATUS_DROPPED;
					tbrh_pkg::CMD_QUERY:
						res_q.status <= slot_ok ? tbrh_pkg::STATUS_OK : tbrh_pkg::STATUS_EMPTY;
					default:
						res_q.status <= tbrh_pkg::STATUS_OK;
				endcase
			end
			tbrh_pkg::ST_SUM, tbrh_pkg::ST_DEV: begin
				if (!walk_done) begin
					bin_q <= bin_q + 1'b1;
				end
				if (state_q == tbrh_pkg::ST_SUM && walk_done && !mac_busy) begin
					n_q <= count_sum;
					if (count_sum == '0) begin
						res_q.status <= tbrh_pkg::STATUS_EMPTY;
					end
				end
			end
			tbrh_pkg::ST_DIV_MEAN: begin
				if (!div_busy) begin
					mean_q <= quotient[tbrh_pkg::M_W-1:0];
					bin_q  <= '0;
				end
			end
			tbrh_pkg::ST_DIV_DEV: begin
				if (!div_busy) begin
					res_q.sample_count <= (n_ext > tbrh_pkg::D_W'(tbrh_pkg::COUNT_OUT_LIMIT))
					                      ? 24'(tbrh_pkg::COUNT_OUT_LIMIT) : n_ext[23:0];
					res_q.mean_q8      <= (mean_ext > tbrh_pkg::D_W'(tbrh_pkg::Q8_LIMIT))
					                      ? 17'(tbrh_pkg::Q8_LIMIT) : mean_ext[16:0];
					res_q.deviation_q8 <= (quotient > tbrh_pkg::D_W'(tbrh_pkg::Q8_LIMIT))
					                      ? 17'(tbrh_pkg::Q8_LIMIT) : quotient[16:0];
				end
			end
			default: ;
		endcase
	end

	// Output register: holds a finished item until the far side takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp <= res_q;
		end
	end

	tbrh_store u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	tbrh_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (mac_ctrl),
		.lowest    (lowest_q),
		.mean      (mean_q),
		.rd_data   (rd_data),
		.busy      (mac_busy),
		.count_sum (count_sum),
		.acc       (acc)
	);

	tbrh_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quotient (quotient)
	);

endmodule

`default_nettype wire
